/* hw/rtl/trma_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trma_pkg
// Shared types and constants for the average true range block.
// ----------------------------------------------------------------------------
package trma_pkg;

	localparam int WINDOW      = 10;
	localparam int PTR_W       = $clog2(WINDOW);
	localparam int BARS_W      = $clog2(WINDOW + 2);
	localparam int SUM_W       = 32 + $clog2(WINDOW);

	// divide by WINDOW as a multiply by the rounded-up reciprocal; the extra
	// fraction bits keep the quotient exact for every window sum
	localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
	localparam int RECIP_W     = SUM_W + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW));

	// both factors split in two halves for four small partial products
	localparam int SPLIT_W     = (SUM_W + 1) / 2;
	localparam int X_HI_W      = SUM_W - SPLIT_W;
	localparam int M_HI_W      = RECIP_W - SPLIT_W;
	localparam int PP_LL_W     = 2 * SPLIT_W;
	localparam int PP_LH_W     = SPLIT_W + M_HI_W;
	localparam int PP_HL_W     = X_HI_W + SPLIT_W;
	localparam int PP_HH_W     = X_HI_W + M_HI_W;
	localparam int CROSS_W     = ((PP_LH_W > PP_HL_W) ? PP_LH_W : PP_HL_W) + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef struct packed {
		logic [31:0] bar_high;
		logic [31:0] bar_low;
		logic [31:0] bar_close;
	} bar_word_t;

	typedef struct packed {
		logic [31:0] true_range;
		logic        range_valid;
		logic [31:0] average_range;
		logic        average_valid;
	} result_word_t;

	// word carried into the divide-by-window stages
	typedef struct packed {
		logic [31:0]      true_range;
		logic             range_valid;
		logic             average_valid;
		logic [SUM_W-1:0] dividend;
	} div_word_t;

endpackage
`default_nettype wire

/* hw/rtl/true_range_moving_average.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// true_range_moving_average
// Per-bar true range and its mean over the last WINDOW bars, Q16.16.
// ----------------------------------------------------------------------------
// usage:
//   bar channel (bar_valid/bar_ready/bar) takes one price word per cycle:
//   high, low and close. result channel (result_valid/result_ready/result)
//   returns one word per bar, in order: the true range, a flag that a
//   previous close existed, the truncated window mean and its valid flag.
//   the mean reads zero and its flag low until WINDOW real ranges exist.
//   pipeline: a taken bar passes the bar register, the range/sum register,
//   then 3 divide registers (partial products, cross sum and final add of
//   the reciprocal multiply) before its result is offered.
//   throughput: one bar per cycle unless stalled; the running sum costs
//   one add and one subtract per bar, the divide is a pipelined multiply.
//   when result_ready is low with a result waiting, the whole pipeline
//   holds and bar_ready drops in the same cycle; bubbles in flight stay.
//   reset clears the history, sum, previous close and bar count, and
//   empties the pipeline; bars are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module true_range_moving_average import trma_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         bar_valid,
	output logic              bar_ready,
	input  wire bar_word_t    bar,
	output logic              result_valid,
	input  wire logic         result_ready,
	output result_word_t      result
);

	logic      adv;
	logic      div_valid;
	div_word_t div_word;

	// pipeline moves unless the output word is stalled
	assign adv       = !result_valid || result_ready;
	assign bar_ready = adv;

	trma_range u_range (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.bar_valid (bar_valid),
		.bar       (bar),
		.valid_s2  (div_valid),
		.word_s2   (div_word)
	);

	trma_div_stage u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.word_valid (div_valid),
		.word       (div_word),
		.valid_s3   (result_valid),
		.result_s3  (result)
	);

endmodule
`default_nettype wire

/* hw/rtl/trma_range.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trma_range
// Input register, true range, range history and running window sum.
// ----------------------------------------------------------------------------
module trma_range import trma_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire logic      bar_valid,
	input  wire bar_word_t bar,
	output logic           valid_s2,
	output div_word_t      word_s2
);

	logic              valid_s1;
	bar_word_t         bar_s1;
	logic [31:0]       prev_close_q;
	logic [31:0]       hist_q [WINDOW];
	logic [SUM_W-1:0]  sum_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [BARS_W-1:0] bars_q;

	logic              first_bar;
	logic [31:0]       d_hl, d_hc, d_cl, tr_max, tr;
	logic [31:0]       old_tr;
	logic [SUM_W-1:0]  sum_next;
	logic [PTR_W-1:0]  ptr_next;
	logic [BARS_W-1:0] bars_next;
	logic              avg_ok;
	logic              take;

	function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	always_comb begin
		first_bar = (bars_q == '0);
		d_hl      = abs_diff(bar_s1.bar_high, bar_s1.bar_low);
		d_hc      = abs_diff(bar_s1.bar_high, prev_close_q);
		d_cl      = abs_diff(prev_close_q, bar_s1.bar_low);
		tr_max    = (d_hc >= d_cl) ? d_hc : d_cl;
		tr_max    = (d_hl >= tr_max) ? d_hl : tr_max;
		tr        = first_bar ? 32'd0 : tr_max;
		old_tr    = hist_q[ptr_q];
		sum_next  = sum_q - SUM_W'(old_tr) + SUM_W'(tr);
		ptr_next  = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
		bars_next = (bars_q < BARS_W'(WINDOW + 1)) ? bars_q + 1'b1 : bars_q;
		avg_ok    = (bars_next == BARS_W'(WINDOW + 1));
		take      = adv && valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			prev_close_q <= '0;
			sum_q        <= '0;
			ptr_q        <= '0;
			bars_q       <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				hist_q[i] <= '0;
			end
		end else if (adv) begin
			valid_s1 <= bar_valid;
			valid_s2 <= valid_s1;
			if (take) begin
				prev_close_q  <= bar_s1.bar_close;
				sum_q         <= sum_next;
				ptr_q         <= ptr_next;
				bars_q        <= bars_next;
				hist_q[ptr_q] <= tr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && bar_valid) begin
			bar_s1 <= bar;
		end
		if (take) begin
			word_s2.true_range    <= tr;
			word_s2.range_valid   <= !first_bar;
			word_s2.average_valid <= avg_ok;
			// average reads as zero until the window is full
			word_s2.dividend      <= avg_ok ? sum_next : '0;
		end
	end

	ap_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q < PTR_W'(WINDOW))
		else $error("history pointer out of range");

	ap_bars_sat: assert property (@(posedge clk) disable iff (!arst_n)
		bars_q <= BARS_W'(WINDOW + 1))
		else $error("bar count past saturation");

	ap_avg_needs_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && word_s2.average_valid |-> word_s2.range_valid)
		else $error("average valid without a valid range");

	ap_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !word_s2.range_valid |-> word_s2.true_range == '0)
		else $error("first bar range not zero");

endmodule
`default_nettype wire

/* hw/rtl/trma_div_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trma_div_stage
// Divide of the window sum by the window length as a reciprocal multiply,
// in three registered steps: partial products, cross sum, final add.
// ----------------------------------------------------------------------------
module trma_div_stage import trma_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire logic      word_valid,
	input  wire div_word_t word,
	output logic           valid_s3,
	output result_word_t   result_s3
);

	logic [SPLIT_W-1:0] x_lo;
	logic [X_HI_W-1:0]  x_hi;
	logic [SPLIT_W-1:0] m_lo;
	logic [M_HI_W-1:0]  m_hi;

	logic               valid_s1;
	logic               valid_s2;
	result_word_t       meta_s1;
	result_word_t       meta_s2;
	logic [PP_LL_W-1:0] pp_ll_s1;
	logic [PP_LH_W-1:0] pp_lh_s1;
	logic [PP_HL_W-1:0] pp_hl_s1;
	logic [PP_HH_W-1:0] pp_hh_s1;
	logic [PROD_W-1:0]  base_s2;
	logic [CROSS_W-1:0] cross_s2;

	logic [PROD_W-1:0]  prod;
	result_word_t       res_d;

	assign x_lo = word.dividend[SPLIT_W-1:0];
	assign x_hi = word.dividend[SUM_W-1:SPLIT_W];
	assign m_lo = RECIP[SPLIT_W-1:0];
	assign m_hi = RECIP[RECIP_W-1:SPLIT_W];

	// quotient sits above the reciprocal's fraction bits
	always_comb begin
		prod                = base_s2 + PROD_W'({cross_s2, {SPLIT_W{1'b0}}});
		res_d               = meta_s2;
		res_d.average_range = prod[RECIP_SHIFT +: 32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= word_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && word_valid) begin
			meta_s1.true_range    <= word.true_range;
			meta_s1.range_valid   <= word.range_valid;
			meta_s1.average_range <= '0;
			meta_s1.average_valid <= word.average_valid;
			pp_ll_s1 <= PP_LL_W'(x_lo) * PP_LL_W'(m_lo);
			pp_lh_s1 <= PP_LH_W'(x_lo) * PP_LH_W'(m_hi);
			pp_hl_s1 <= PP_HL_W'(x_hi) * PP_HL_W'(m_lo);
			pp_hh_s1 <= PP_HH_W'(x_hi) * PP_HH_W'(m_hi);
		end
		if (adv && valid_s1) begin
			meta_s2  <= meta_s1;
			base_s2  <= {pp_hh_s1, pp_ll_s1};
			cross_s2 <= CROSS_W'(pp_lh_s1) + CROSS_W'(pp_hl_s1);
		end
		if (adv && valid_s2) begin
			result_s3 <= res_d;
		end
	end

	ap_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !result_s3.average_valid |-> result_s3.average_range == '0)
		else $error("average not zero before the window is full");

	ap_avg_needs_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && result_s3.average_valid |-> result_s3.range_valid)
		else $error("average valid without a valid range");

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv |=> valid_s3 && $stable(result_s3))
		else $error("stalled result word changed");

endmodule
`default_nettype wire
